/* hdl/voxel_density_trilinear_sampler_unit_assert.svh */
// assertion macros for the sampler rtl
`ifndef VOXEL_DENSITY_TRILINEAR_SAMPLER_UNIT_ASSERT_SVH
`define VOXEL_DENSITY_TRILINEAR_SAMPLER_UNIT_ASSERT_SVH

// same-cycle implication, quiet during reset
`define VDTS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("vdts check failed");

// next-cycle implication, quiet during reset
`define VDTS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("vdts check failed");

`endif

/* hdl/vdts_pkg.sv */
`default_nettype none
package vdts_pkg;
    localparam int GRID_SIDE  = 34;
    localparam int FRAC_BITS  = 8;
    localparam int POS_W      = 16;
    localparam int VAL_W      = 32;
    localparam int KIND_W     = 2;
    localparam int CRD_W      = $clog2(GRID_SIDE);
    localparam int LAST       = GRID_SIDE - 1;
    localparam int HALF       = (GRID_SIDE + 1) / 2;
    localparam int BANK_DEPTH = HALF * HALF * HALF;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);
    localparam int NBANK      = 8;
    localparam int FR_W       = FRAC_BITS + 1;
    localparam int FRAC_ONE   = 1 << FRAC_BITS;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD  = 2'd0,
        KIND_TRI   = 2'd1,
        KIND_POINT = 2'd2
    } t_kind;

    // stage b payload: bank addresses and blend controls
    typedef struct packed {
        logic                              is_load;
        logic [NBANK-1:0][BANK_AW-1:0]     addr;
        logic [2:0]                        par_lo;
        logic [2:0]                        par_hi;
        logic [2:0][FR_W-1:0]              fr;
        logic [VAL_W-1:0]                  wdata;
    } t_stage_b;

    // stage c controls that ride along with the bank read data
    typedef struct packed {
        logic [2:0]           par_lo;
        logic [2:0]           par_hi;
        logic [2:0][FR_W-1:0] fr;
    } t_stage_c;

    // floor-shift lerp: (a*(1-f) + b*f) >> FRAC_BITS
    function automatic logic signed [VAL_W-1:0] lerp(
        input logic signed [VAL_W-1:0] a,
        input logic signed [VAL_W-1:0] b,
        input logic [FR_W-1:0]         f
    );
        logic [FR_W-1:0]                w;
        logic signed [VAL_W+FR_W:0]     pa;
        logic signed [VAL_W+FR_W:0]     pb;
        logic signed [VAL_W+FR_W+1:0]   s;
        w  = FR_W'(FRAC_ONE) - f;
        pa = a * $signed({1'b0, w});
        pb = b * $signed({1'b0, f});
        s  = (VAL_W+FR_W+2)'(pa) + (VAL_W+FR_W+2)'(pb);
        return VAL_W'(s >>> FRAC_BITS);
    endfunction
endpackage
`default_nettype wire

/* hdl/vdts_if.sv */
`default_nettype none
interface vdts_req_if import vdts_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [KIND_W-1:0]       kind;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [VAL_W-1:0] load_value;
    modport source(output valid, kind, pos_x, pos_y, pos_z, load_value, input ready);
    modport sink(input valid, kind, pos_x, pos_y, pos_z, load_value, output ready);
endinterface

interface vdts_rsp_if import vdts_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] sample_value;
    modport source(output valid, sample_value, input ready);
    modport sink(input valid, sample_value, output ready);
endinterface
`default_nettype wire

/* hdl/vdts_addr.sv */
`default_nettype none
module vdts_addr import vdts_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    vdts_req_if.sink   i_req,
    input  wire logic  i_adv_c,
    output logic       o_vb,
    output t_stage_b   o_stb
);
    logic                     r_va;
    logic                     r_a_load;
    logic [CRD_W-1:0]         r_a_lo [0:2];
    logic [CRD_W-1:0]         r_a_hi [0:2];
    logic [FR_W-1:0]          r_a_fr [0:2];
    logic [VAL_W-1:0]         r_a_val;
    logic                     r_vb;
    t_stage_b                 r_b;

    logic                     adv_a;
    logic                     adv_b;
    logic                     n_va;
    logic                     n_load;
    logic                     in_grid;
    logic signed [POS_W-1:0]  pos [0:2];
    logic signed [POS_W-1:0]  ip  [0:2];
    logic signed [POS_W+1:0]  d   [0:2];
    logic [CRD_W-1:0]         n_lo [0:2];
    logic [CRD_W-1:0]         n_hi [0:2];
    logic [FR_W-1:0]          n_fr [0:2];
    t_stage_b                 n_b;
    logic [CRD_W-1:0]         cx, cy, cz;
    logic [CRD_W-2:0]         hx, hy, hz;

    // stall chain: a stage takes new data when empty or draining
    assign adv_b       = !r_vb || i_adv_c;
    assign adv_a       = !r_va || adv_b;
    assign i_req.ready = adv_a;

    // coordinate decode: floor, clamp, upper corner, fraction
    always_comb begin
        pos[0]  = i_req.pos_x;
        pos[1]  = i_req.pos_y;
        pos[2]  = i_req.pos_z;
        in_grid = 1'b1;
        for (int k = 0; k < 3; k++) begin
            ip[k] = pos[k] >>> FRAC_BITS;
            if (ip[k] < 0 || int'(ip[k]) > LAST) in_grid = 1'b0;
            if (ip[k] < 0) begin
                n_lo[k] = '0;
            end else if (int'(ip[k]) > LAST) begin
                n_lo[k] = CRD_W'(LAST);
            end else begin
                n_lo[k] = ip[k][CRD_W-1:0];
            end
            d[k] = (POS_W+2)'(pos[k]) - (POS_W+2)'({n_lo[k], {FRAC_BITS{1'b0}}});
            if (d[k][POS_W+1]) begin
                n_fr[k] = '0;
            end else if (d[k] > (POS_W+2)'(FRAC_ONE)) begin
                n_fr[k] = FR_W'(FRAC_ONE);
            end else begin
                n_fr[k] = d[k][FR_W-1:0];
            end
            n_hi[k] = (n_lo[k] == CRD_W'(LAST)) ? n_lo[k] : n_lo[k] + 1'b1;
        end
        n_load = 1'b0;
        case (t_kind'(i_req.kind))
            KIND_LOAD: begin
                n_va   = in_grid;
                n_load = 1'b1;
            end
            KIND_TRI: begin
                n_va = 1'b1;
            end
            KIND_POINT: begin
                n_va = 1'b1;
            end
            default: begin
                n_va = 1'b0;
            end
        endcase
        // loads and point reads use only the base corner
        if (t_kind'(i_req.kind) != KIND_TRI) begin
            for (int k = 0; k < 3; k++) begin
                n_hi[k] = n_lo[k];
                n_fr[k] = '0;
            end
        end
        n_va = n_va && i_req.valid;
    end

    // stage a registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (adv_a) begin
            r_va <= n_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_a) begin
            r_a_load <= n_load;
            r_a_lo   <= n_lo;
            r_a_hi   <= n_hi;
            r_a_fr   <= n_fr;
            r_a_val  <= i_req.load_value;
        end
    end

    // per-bank addresses: each bank holds one parity class of x, y, z
    always_comb begin
        n_b.is_load = r_a_load;
        n_b.wdata   = r_a_val;
        for (int k = 0; k < 3; k++) begin
            n_b.par_lo[k] = r_a_lo[k][0];
            n_b.par_hi[k] = r_a_hi[k][0];
            n_b.fr[k]     = r_a_fr[k];
        end
        for (int j = 0; j < NBANK; j++) begin
            cx = (r_a_lo[0][0] == j[0]) ? r_a_lo[0] : r_a_hi[0];
            cy = (r_a_lo[1][0] == j[1]) ? r_a_lo[1] : r_a_hi[1];
            cz = (r_a_lo[2][0] == j[2]) ? r_a_lo[2] : r_a_hi[2];
            hx = cx[CRD_W-1:1];
            hy = cy[CRD_W-1:1];
            hz = cz[CRD_W-1:1];
            n_b.addr[j] = BANK_AW'(hx) + BANK_AW'(HALF) * BANK_AW'(hy)
                        + BANK_AW'(HALF * HALF) * BANK_AW'(hz);
        end
    end

    // stage b registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (adv_b) begin
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_b) begin
            r_b <= n_b;
        end
    end

    assign o_vb  = r_vb;
    assign o_stb = r_b;
endmodule
`default_nettype wire

/* hdl/vdts_bank.sv */
`default_nettype none
module vdts_bank import vdts_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_we,
    input  wire logic               i_re,
    input  wire logic [BANK_AW-1:0] i_addr,
    input  wire logic [VAL_W-1:0]   i_wdata,
    output logic      [VAL_W-1:0]   o_rdata
);
    logic [VAL_W-1:0] r_mem [BANK_DEPTH];
    logic [VAL_W-1:0] r_rdata;

    // single port: write or registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

/* hdl/vdts_blend.sv */
`default_nettype none
module vdts_blend import vdts_pkg::*; (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_vc,
    input  wire t_stage_c                     i_stc,
    input  wire logic [NBANK-1:0][VAL_W-1:0]  i_rdata,
    output logic                              o_adv_d,
    vdts_rsp_if.source                        o_rsp
);
    logic                     r_vd;
    logic signed [VAL_W-1:0]  r_d [0:3];
    logic [FR_W-1:0]          r_d_fy;
    logic [FR_W-1:0]          r_d_fz;
    logic                     r_ve;
    logic signed [VAL_W-1:0]  r_e [0:1];
    logic [FR_W-1:0]          r_e_fz;
    logic                     r_vf;
    logic signed [VAL_W-1:0]  r_f;

    logic                     adv_d;
    logic                     adv_e;
    logic                     adv_f;
    logic [2:0]               bsel;
    logic signed [VAL_W-1:0]  corner [0:NBANK-1];
    logic signed [VAL_W-1:0]  n_d    [0:3];

    assign adv_f   = !r_vf || o_rsp.ready;
    assign adv_e   = !r_ve || adv_f;
    assign adv_d   = !r_vd || adv_e;
    assign o_adv_d = adv_d;

    // route each corner to the bank that holds its parity class
    always_comb begin
        for (int j = 0; j < NBANK; j++) begin
            bsel[0]   = j[0] ? i_stc.par_hi[0] : i_stc.par_lo[0];
            bsel[1]   = j[1] ? i_stc.par_hi[1] : i_stc.par_lo[1];
            bsel[2]   = j[2] ? i_stc.par_hi[2] : i_stc.par_lo[2];
            corner[j] = $signed(i_rdata[bsel]);
        end
        for (int k = 0; k < 4; k++) begin
            n_d[k] = lerp(corner[2*k], corner[2*k+1], i_stc.fr[0]);
        end
    end

    // stage d: blends along x
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd <= 1'b0;
        end else if (adv_d) begin
            r_vd <= i_vc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_d) begin
            r_d    <= n_d;
            r_d_fy <= i_stc.fr[1];
            r_d_fz <= i_stc.fr[2];
        end
    end

    // stage e: blends along y
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ve <= 1'b0;
        end else if (adv_e) begin
            r_ve <= r_vd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_e) begin
            r_e[0] <= lerp(r_d[0], r_d[1], r_d_fy);
            r_e[1] <= lerp(r_d[2], r_d[3], r_d_fy);
            r_e_fz <= r_d_fz;
        end
    end

    // stage f: blend along z, output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf <= 1'b0;
        end else if (adv_f) begin
            r_vf <= r_ve;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_f) begin
            r_f <= lerp(r_e[0], r_e[1], r_e_fz);
        end
    end

    assign o_rsp.valid        = r_vf;
    assign o_rsp.sample_value = r_f;
endmodule
`default_nettype wire

/* hdl/voxel_density_trilinear_sampler_unit.sv */
// a sampling transaction passes stages a, b, c, d, e and f on its way to o_rsp
// throughput: one transaction per cycle unless o_rsp stalls; eight parity banks serve all corners at once
// loads and unused kinds give no result; a stall holds every occupied stage in place
// reset clears the pipeline valid bits only; store entries are undefined until loaded
`default_nettype none
module voxel_density_trilinear_sampler_unit import vdts_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    vdts_req_if.sink   i_req,
    vdts_rsp_if.source o_rsp
);
    `include "voxel_density_trilinear_sampler_unit_assert.svh"

    logic                          vb;
    t_stage_b                      stb;
    logic                          adv_c;
    logic                          adv_d;
    logic [NBANK-1:0]              bank_we;
    logic                          bank_re;
    logic [NBANK-1:0][VAL_W-1:0]   rdata;
    logic                          r_vc;
    t_stage_c                      r_c;

    vdts_addr u_addr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_adv_c (adv_c),
        .o_vb    (vb),
        .o_stb   (stb)
    );

    assign adv_c   = !r_vc || adv_d;
    assign bank_re = adv_c && vb && !stb.is_load;

    // a load writes the single bank matching its parity class
    always_comb begin
        for (int j = 0; j < NBANK; j++) begin
            bank_we[j] = adv_c && vb && stb.is_load && (stb.par_lo == 3'(j));
        end
    end

    for (genvar g = 0; g < NBANK; g++) begin : g_bank
        vdts_bank u_bank (
            .i_clk   (i_clk),
            .i_we    (bank_we[g]),
            .i_re    (bank_re),
            .i_addr  (stb.addr[g]),
            .i_wdata (stb.wdata),
            .o_rdata (rdata[g])
        );
    end

    // stage c: controls travel with the bank read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
        end else if (adv_c) begin
            r_vc <= vb && !stb.is_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_c) begin
            r_c.par_lo <= stb.par_lo;
            r_c.par_hi <= stb.par_hi;
            r_c.fr     <= stb.fr;
        end
    end

    vdts_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vc    (r_vc),
        .i_stc   (r_c),
        .i_rdata (rdata),
        .o_adv_d (adv_d),
        .o_rsp   (o_rsp)
    );

    `VDTS_ASSERT_SAME(a_one_bank_write, 1'b1, $onehot0(bank_we))
    `VDTS_ASSERT_NEXT(a_load_no_result, bank_we != '0, !r_vc)
    `VDTS_ASSERT_NEXT(a_read_held, r_vc && !adv_d, r_vc)
endmodule
`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 1ps
module testbench;
    import vdts_pkg::*;

    localparam int               STORE_DEPTH = GRID_SIDE * GRID_SIDE * GRID_SIDE;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int               IDLE_LIMIT  = 20000;
    localparam int               DRAIN_WAIT  = 20;

    logic i_clk;
    logic i_rst_n;

    vdts_req_if req_if ();
    vdts_rsp_if rsp_if ();

    voxel_density_trilinear_sampler_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // shadow copy of the density store and pending sample results
    int density_mirror [STORE_DEPTH];
    logic signed [VAL_W-1:0] sample_queue [$];

    int req_count;
    int err_count;
    int idle_cycles;
    int burst_left;
    int gap_max;
    int stall_mode;
    int stall_phase;

    // clock
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    task automatic report(input string what, input logic signed [VAL_W-1:0] got,
                          input logic signed [VAL_W-1:0] want);
        err_count++;
        $display("mismatch %s: got %08h want %08h at %0t", what, got, want, $realtime);
    endtask

    function automatic int cell_index(input int x, input int y, input int z);
        return x + GRID_SIDE * (y + GRID_SIDE * z);
    endfunction

    function automatic longint lerp_floor(input longint a, input longint b, input longint f);
        return (a * (FRAC_ONE - f) + b * f) >>> FRAC_BITS;
    endfunction

    function automatic int clamp_grid(input int v);
        return v < 0 ? 0 : (v > LAST ? LAST : v);
    endfunction

    // apply one accepted transaction to the shadow store; queue a result if any
    task automatic predict_density(input logic [KIND_W-1:0] kind,
                                   input logic signed [POS_W-1:0] px,
                                   input logic signed [POS_W-1:0] py,
                                   input logic signed [POS_W-1:0] pz,
                                   input logic signed [VAL_W-1:0] lv);
        int     ip [3];
        int     lo [3];
        int     hi [3];
        longint fr [3];
        longint c00, c10, c01, c11, c0, c1;
        ip[0] = int'(px) >>> FRAC_BITS;
        ip[1] = int'(py) >>> FRAC_BITS;
        ip[2] = int'(pz) >>> FRAC_BITS;
        if (kind == KIND_LOAD) begin
            if (ip[0] >= 0 && ip[0] <= LAST && ip[1] >= 0 && ip[1] <= LAST &&
                ip[2] >= 0 && ip[2] <= LAST)
                density_mirror[cell_index(ip[0], ip[1], ip[2])] = lv;
        end else if (kind == KIND_POINT) begin
            sample_queue.push_back(density_mirror[cell_index(clamp_grid(ip[0]),
                                   clamp_grid(ip[1]), clamp_grid(ip[2]))]);
        end else if (kind == KIND_TRI) begin
            for (int k = 0; k < 3; k++) begin
                lo[k] = clamp_grid(ip[k]);
                hi[k] = lo[k] + 1 > LAST ? LAST : lo[k] + 1;
            end
            fr[0] = longint'(px) - lo[0] * FRAC_ONE;
            fr[1] = longint'(py) - lo[1] * FRAC_ONE;
            fr[2] = longint'(pz) - lo[2] * FRAC_ONE;
            for (int k = 0; k < 3; k++)
                fr[k] = fr[k] < 0 ? 0 : (fr[k] > FRAC_ONE ? FRAC_ONE : fr[k]);
            c00 = lerp_floor(density_mirror[cell_index(lo[0], lo[1], lo[2])],
                             density_mirror[cell_index(hi[0], lo[1], lo[2])], fr[0]);
            c10 = lerp_floor(density_mirror[cell_index(lo[0], hi[1], lo[2])],
                             density_mirror[cell_index(hi[0], hi[1], lo[2])], fr[0]);
            c01 = lerp_floor(density_mirror[cell_index(lo[0], lo[1], hi[2])],
                             density_mirror[cell_index(hi[0], lo[1], hi[2])], fr[0]);
            c11 = lerp_floor(density_mirror[cell_index(lo[0], hi[1], hi[2])],
                             density_mirror[cell_index(hi[0], hi[1], hi[2])], fr[0]);
            c0 = lerp_floor(c00, c10, fr[1]);
            c1 = lerp_floor(c01, c11, fr[1]);
            sample_queue.push_back(VAL_W'(lerp_floor(c0, c1, fr[2])));
        end
    endtask

    // monitor: check results, predict on requests, watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (sample_queue.size() == 0)
                    report("unexpected sample", rsp_if.sample_value, '0);
                else if (rsp_if.sample_value !== sample_queue[0])
                    report("sample_value", rsp_if.sample_value, sample_queue.pop_front());
                else
                    void'(sample_queue.pop_front());
            end
            if (req_if.valid && req_if.ready) begin
                predict_density(req_if.kind, req_if.pos_x, req_if.pos_y, req_if.pos_z,
                                req_if.load_value);
                req_count <= req_count + 1;
            end
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // receiver stall pattern
    always @(negedge i_clk) begin
        stall_phase <= stall_phase + 1;
        case (stall_mode)
            0: begin
                rsp_if.ready <= 1'b1;
            end
            1: begin
                rsp_if.ready <= ($urandom_range(0, 9) < 7);
            end
            default: begin
                rsp_if.ready <= (stall_phase % 11) > 4;
            end
        endcase
    end

    // drive one transaction at a falling edge, return once it is accepted
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic signed [POS_W-1:0] px,
                             input logic signed [POS_W-1:0] py,
                             input logic signed [POS_W-1:0] pz,
                             input logic signed [VAL_W-1:0] lv);
        int target;
        if (burst_left == 0) begin
            req_if.valid = 1'b0;
            repeat ($urandom_range(0, gap_max)) @(negedge i_clk);
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        req_if.valid      = 1'b1;
        req_if.kind       = kind;
        req_if.pos_x      = px;
        req_if.pos_y      = py;
        req_if.pos_z      = pz;
        req_if.load_value = lv;
        target = req_count + 1;
        do @(negedge i_clk); while (req_count < target);
    endtask

    task automatic wait_drained();
        req_if.valid = 1'b0;
        while (sample_queue.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic signed [VAL_W-1:0] rand_density();
        case ($urandom_range(0, 7))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return '0;
            default: return $urandom;
        endcase
    endfunction

    // low end of the grid, high end with clamping, or far outside on either side
    function automatic logic signed [POS_W-1:0] rand_pos();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return POS_W'($urandom_range(0, 3 * FRAC_ONE - 1));
        if (sel < 8)
            return POS_W'($urandom_range((LAST - 3) * FRAC_ONE, (GRID_SIDE + 2) * FRAC_ONE));
        if (sel == 8)
            return POS_W'(-int'($urandom_range(1, 32768)));
        return POS_W'($urandom_range(GRID_SIDE * FRAC_ONE, 32767));
    endfunction

    function automatic logic signed [POS_W-1:0] grid_pos(input int i);
        return POS_W'(i * FRAC_ONE + $urandom_range(0, FRAC_ONE - 1));
    endfunction

    // four lowest then four highest indexes of an axis
    function automatic int fill_coord(input int a);
        return a < 4 ? a : LAST - 7 + a;
    endfunction

    // entries near both ends of every axis loaded once; queries only touch these
    task automatic test_fill_store();
        gap_max = 2;
        for (int z = 0; z < 8; z++)
            for (int y = 0; y < 8; y++)
                for (int x = 0; x < 8; x++)
                    send_item(KIND_LOAD, grid_pos(fill_coord(x)), grid_pos(fill_coord(y)),
                              grid_pos(fill_coord(z)), rand_density());
        wait_drained();
    endtask

    // corners, fraction extremes, clamping, ignored kinds and stray loads
    task automatic test_directed();
        gap_max    = 4;
        stall_mode = 1;
        send_item(KIND_LOAD, 16'sd0, 16'sd0, 16'sd0, 32'sh7fffffff);
        send_item(KIND_LOAD, 16'sh0100, 16'sd0, 16'sd0, 32'sh80000000);
        send_item(KIND_TRI, 16'sd0, 16'sd0, 16'sd0, '0);
        send_item(KIND_TRI, 16'sh0080, 16'sd0, 16'sd0, '0);
        send_item(KIND_TRI, 16'sh00ff, 16'sh00ff, 16'sh00ff, '0);
        send_item(KIND_TRI, 16'sh7fff, 16'sh7fff, 16'sh7fff, '0);
        send_item(KIND_TRI, 16'sh8000, 16'sh8000, 16'sh8000, '0);
        send_item(KIND_TRI, 16'sh2180, 16'sh2100, 16'sh20ff, '0);
        send_item(KIND_TRI, -16'sd1, 16'sh2280, 16'sh0001, '0);
        send_item(KIND_POINT, 16'sd0, 16'sd0, 16'sd0, '0);
        send_item(KIND_POINT, 16'sh7fff, 16'sh7fff, 16'sh7fff, '0);
        send_item(KIND_POINT, 16'sh8000, 16'sh8000, 16'sh8000, '0);
        send_item(KIND_POINT, 16'sh0100, -16'sd1, 16'sh2100, '0);
        send_item(KIND_LOAD, -16'sd1, 16'sd0, 16'sd0, 32'sh12345678);
        send_item(KIND_LOAD, 16'sd0, 16'sh2200, 16'sd0, 32'sh12345678);
        send_item(KIND_LOAD, 16'sd0, 16'sd0, 16'sh7fff, 32'sh12345678);
        send_item(KIND_UNUSED, 16'sd0, 16'sd0, 16'sd0, 32'shffffffff);
        send_item(KIND_UNUSED, 16'sh7fff, 16'sh8000, 16'sh7fff, 32'sh0);
        send_item(KIND_POINT, 16'sd0, 16'sd0, 16'sd0, '0);
        send_item(KIND_POINT, -16'sd1, 16'sd0, 16'sd0, '0);
        send_item(KIND_TRI, 16'sh0040, 16'sd0, 16'sd0, '0);
        wait_drained();
    endtask

    // random mix under a given stall pattern, pausing for drain once in a while
    task automatic test_random(input int count, input int mode, input int gaps);
        int           pick;
        logic [KIND_W-1:0] kind;
        stall_mode = mode;
        gap_max    = gaps;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 19);
            if (pick < 9)       kind = KIND_TRI;
            else if (pick < 14) kind = KIND_POINT;
            else if (pick < 19) kind = KIND_LOAD;
            else                kind = KIND_UNUSED;
            send_item(kind, rand_pos(), rand_pos(), rand_pos(), rand_density());
            if (n % 150 == 149)
                wait_drained();
        end
        wait_drained();
    endtask

    initial begin
        i_rst_n           = 1'b0;
        req_if.valid      = 1'b0;
        req_if.kind       = KIND_LOAD;
        req_if.pos_x      = '0;
        req_if.pos_y      = '0;
        req_if.pos_z      = '0;
        req_if.load_value = '0;
        rsp_if.ready      = 1'b0;
        req_count         = 0;
        err_count         = 0;
        idle_cycles       = 0;
        burst_left        = 0;
        gap_max           = 0;
        stall_mode        = 0;
        stall_phase       = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_fill_store();
        test_directed();
        test_random(270, 0, 0);
        test_random(270, 1, 3);
        test_random(270, 2, 6);
        test_random(270, 1, 1);

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (err_count == 0 && sample_queue.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
